// ----- rtl/pcd_pkg.sv -----
// Shared types, constants and helper functions for the plot command decoder.
// Used by every module of the block; depends on nothing else.
package pcd_pkg;

  localparam int DEF_SCREEN_WIDTH   = 800;
  localparam int DEF_SCREEN_HEIGHT  = 600;
  localparam int DEF_LOGICAL_WIDTH  = 1280;
  localparam int DEF_LOGICAL_HEIGHT = 1024;

  localparam int QDEPTH      = 2;
  localparam int ROOT_STEPS  = 17;
  localparam int SQ_W        = 34;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 152;
  localparam int CFG_AW      = 4;

  typedef enum logic [2:0] {
    PRIM_NONE,
    PRIM_LINE,
    PRIM_POINT,
    PRIM_TRIANGLE,
    PRIM_RECTANGLE,
    PRIM_CIRCLE,
    PRIM_DISC
  } prim_t;

  localparam logic [1:0] CMODE_MOVE   = 2'd0;
  localparam logic [1:0] CMODE_FG     = 2'd1;
  localparam logic [1:0] CMODE_INVERT = 2'd2;
  localparam logic [1:0] CMODE_BG     = 2'd3;

  localparam logic [7:0] GRP_MASK      = 8'hF8;
  localparam logic [7:0] GRP_MOVE      = 8'h00;
  localparam logic [7:0] GRP_POINT     = 8'h40;
  localparam logic [7:0] GRP_TRIANGLE  = 8'h50;
  localparam logic [7:0] GRP_RECTANGLE = 8'h60;
  localparam logic [7:0] GRP_CIRCLE    = 8'h90;
  localparam logic [7:0] GRP_DISC      = 8'h98;

  localparam logic [2:0] ROP_EOR = 3'd3;

  typedef enum logic [1:0] {
    REG_ENABLE,
    REG_FG,
    REG_BG,
    REG_ACTION
  } reg_idx_t;

  localparam logic       RST_ENABLE = 1'b0;
  localparam logic [2:0] RST_FG     = 3'd7;
  localparam logic [2:0] RST_BG     = 3'd0;
  localparam logic [2:0] RST_ACTION = 3'd0;

  typedef struct packed {
    logic       enable;
    logic [2:0] fg;
    logic [2:0] bg;
    logic [2:0] action;
  } cfg_t;

  // Coordinates in order: newest x, newest y, previous x, previous y,
  // oldest x, oldest y.
  typedef struct packed {
    prim_t            prim;
    logic [2:0]       rop;
    logic [31:0]      colour;
    logic [5:0][15:0] coord;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_SCALE,
    BK_SQR,
    BK_SUM,
    BK_ROOT,
    BK_DONE
  } bk_state_t;

  // ABGR word: index bit 0 lights red, bit 1 green, bit 2 blue.
  function automatic logic [31:0] palette_word(input logic [2:0] idx);
    return {8'hFF, {8{idx[2]}}, {8{idx[1]}}, {8{idx[0]}}};
  endfunction

endpackage

// ----- rtl/pcd_regs.sv -----
// Configuration register bank with an APB-style slave port.
// Depends on pcd_pkg for the register indexes, reset values and cfg_t.
module pcd_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [pcd_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready,
  output pcd_pkg::cfg_t              cfg
);

  pcd_pkg::cfg_t     cfg_r;
  pcd_pkg::cfg_t     cfg_nxt;
  pcd_pkg::reg_idx_t idx;
  logic              wr;

  assign cfg_pready = 1'b1;
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign idx        = pcd_pkg::reg_idx_t'(cfg_paddr[3:2]);
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (idx)
        pcd_pkg::REG_ENABLE: cfg_nxt.enable = cfg_pwdata[0];
        pcd_pkg::REG_FG:     cfg_nxt.fg     = cfg_pwdata[2:0];
        pcd_pkg::REG_BG:     cfg_nxt.bg     = cfg_pwdata[2:0];
        pcd_pkg::REG_ACTION: cfg_nxt.action = cfg_pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      pcd_pkg::REG_ENABLE: cfg_prdata = {31'd0, cfg_r.enable};
      pcd_pkg::REG_FG:     cfg_prdata = {29'd0, cfg_r.fg};
      pcd_pkg::REG_BG:     cfg_prdata = {29'd0, cfg_r.bg};
      pcd_pkg::REG_ACTION: cfg_prdata = {29'd0, cfg_r.action};
      default:             cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable <= pcd_pkg::RST_ENABLE;
      cfg_r.fg     <= pcd_pkg::RST_FG;
      cfg_r.bg     <= pcd_pkg::RST_BG;
      cfg_r.action <= pcd_pkg::RST_ACTION;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- rtl/pcd_front.sv -----
// Front end: accepts plot command items, keeps the three-point history and
// classifies each item into a queued command. Depends on pcd_pkg.
module pcd_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pcd_pkg::cfg_t                  cfg,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tuser,  // plot_code[7:0]
  input  logic [pcd_pkg::IN_TDATA_W-1:0] in_tdata,  // coord_x[15:0], coord_y[31:16]
  input  pcd_pkg::q_stat_t               q_stat,
  output pcd_pkg::q_push_t               q_push
);

  logic [15:0] newx_r, newy_r, prevx_r, prevy_r;
  logic [15:0] newx_nxt, newy_nxt, prevx_nxt, prevy_nxt;
  logic [15:0] nx, ny, cx, cy;
  logic [7:0]  grp;
  logic [1:0]  cmode;
  logic        accept;
  logic        blank;
  pcd_pkg::prim_t prim;

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;
  assign cx        = in_tdata[15:0];
  assign cy        = in_tdata[31:16];
  assign grp       = in_tuser & pcd_pkg::GRP_MASK;
  assign cmode     = in_tuser[1:0];
  assign nx        = in_tuser[2] ? cx : newx_r + cx;
  assign ny        = in_tuser[2] ? cy : newy_r + cy;
  assign blank     = !cfg.enable ||
                     (grp == pcd_pkg::GRP_MOVE && cmode == pcd_pkg::CMODE_MOVE);

  always_comb begin
    case (grp)
      pcd_pkg::GRP_POINT:     prim = pcd_pkg::PRIM_POINT;
      pcd_pkg::GRP_TRIANGLE:  prim = pcd_pkg::PRIM_TRIANGLE;
      pcd_pkg::GRP_RECTANGLE: prim = pcd_pkg::PRIM_RECTANGLE;
      pcd_pkg::GRP_CIRCLE:    prim = pcd_pkg::PRIM_CIRCLE;
      pcd_pkg::GRP_DISC:      prim = pcd_pkg::PRIM_DISC;
      default:                prim = pcd_pkg::PRIM_LINE;
    endcase
  end

  always_comb begin
    q_push.valid = accept;
    if (blank) begin
      q_push.cmd.prim   = pcd_pkg::PRIM_NONE;
      q_push.cmd.rop    = 3'd0;
      q_push.cmd.colour = 32'd0;
      q_push.cmd.coord  = '0;
    end else begin
      q_push.cmd.prim   = prim;
      q_push.cmd.rop    = (cmode == pcd_pkg::CMODE_INVERT) ? pcd_pkg::ROP_EOR : cfg.action;
      q_push.cmd.colour = pcd_pkg::palette_word((cmode == pcd_pkg::CMODE_BG) ? cfg.bg
                                                                             : cfg.fg);
      q_push.cmd.coord  = {prevy_r, prevx_r, newy_r, newx_r, ny, nx};
    end
  end

  always_comb begin
    newx_nxt  = newx_r;
    newy_nxt  = newy_r;
    prevx_nxt = prevx_r;
    prevy_nxt = prevy_r;
    if (accept && cfg.enable) begin
      newx_nxt  = nx;
      newy_nxt  = ny;
      prevx_nxt = newx_r;
      prevy_nxt = newy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      newx_r  <= 16'd0;
      newy_r  <= 16'd0;
      prevx_r <= 16'd0;
      prevy_r <= 16'd0;
    end else begin
      newx_r  <= newx_nxt;
      newy_r  <= newy_nxt;
      prevx_r <= prevx_nxt;
      prevy_r <= prevy_nxt;
    end
  end

endmodule

// ----- rtl/pcd_fifo.sv -----
// Short command queue between the front end and the back end.
// Depends on pcd_pkg for cmd_t, the push and status structs and its depth.
module pcd_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  pcd_pkg::q_push_t q_push,
  input  logic             pop,
  output pcd_pkg::cmd_t    head,
  output pcd_pkg::q_stat_t q_stat
);

  localparam int AW = (pcd_pkg::QDEPTH > 1) ? $clog2(pcd_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(pcd_pkg::QDEPTH + 1);

  pcd_pkg::cmd_t mem_r [pcd_pkg::QDEPTH];
  logic [AW-1:0] wp_r, rp_r, wp_nxt, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          push_ok, pop_ok;

  assign q_stat.full  = (cnt_r == CW'(pcd_pkg::QDEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign push_ok      = q_push.valid && !q_stat.full;
  assign pop_ok       = pop && !q_stat.empty;
  assign head         = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push_ok) begin
      wp_nxt = (wp_r == AW'(pcd_pkg::QDEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop_ok) begin
      rp_nxt = (rp_r == AW'(pcd_pkg::QDEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wp_r] <= q_push.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/pcd_back.sv -----
// Back end: scales the three points by reciprocal multiplication, computes the
// circle radius with a bit-pair square root and holds the output item. Uses pcd_pkg.
module pcd_back #(
  parameter int SCREEN_WIDTH   = pcd_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT  = pcd_pkg::DEF_SCREEN_HEIGHT,
  parameter int LOGICAL_WIDTH  = pcd_pkg::DEF_LOGICAL_WIDTH,
  parameter int LOGICAL_HEIGHT = pcd_pkg::DEF_LOGICAL_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pcd_pkg::q_stat_t                q_stat,
  input  pcd_pkg::cmd_t                   head,
  output logic                            pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [2:0]                      out_tuser,  // primitive_res[2:0]
  // raster_op[2:0], colour_word[34:3], newest_px[50:35], newest_py[66:51],
  // previous_px[82:67], previous_py[98:83], oldest_px[114:99],
  // oldest_py[130:115], circle_radius[146:131], zero fill above
  output logic [pcd_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int SMAX  = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
  localparam int PW    = 17 + $clog2(SMAX + 1);
  localparam int RW    = PW + 1;
  localparam int QW    = PW + RW;
  localparam int KX    = PW + $clog2(LOGICAL_WIDTH);
  localparam int KY    = PW + $clog2(LOGICAL_HEIGHT);
  localparam int CNT_W = $clog2(pcd_pkg::ROOT_STEPS + 1);
  localparam int PAD_W = pcd_pkg::OUT_TDATA_W - 147;

  // Rounded-up reciprocals; the products stay below 2^PW, so the quotient is exact.
  localparam logic [RW-1:0] RCP_X  =
    RW'(((longint'(1) << KX) + longint'(LOGICAL_WIDTH) - 1) / longint'(LOGICAL_WIDTH));
  localparam logic [RW-1:0] RCP_Y  =
    RW'(((longint'(1) << KY) + longint'(LOGICAL_HEIGHT) - 1) / longint'(LOGICAL_HEIGHT));
  localparam logic [PW-1:0] MUL_X  = PW'(SCREEN_WIDTH);
  localparam logic [PW-1:0] MUL_Y  = PW'(SCREEN_HEIGHT);
  localparam logic [15:0]   PY_TOP = 16'(SCREEN_HEIGHT - 1);

  pcd_pkg::bk_state_t state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  pcd_pkg::prim_t     prim_r, prim_nxt;
  logic [2:0]         rop_r, rop_nxt;
  logic [31:0]        colour_r, colour_nxt;

  logic [5:0][PW-1:0] mag_r, mag_nxt, quo_r, quo_nxt, prod, qv;
  logic [5:0][QW-1:0] qprod;
  logic [5:0]         neg_r, neg_nxt;
  logic [5:0][16:0]   absv;
  logic [5:0][15:0]   pix_r, pix_nxt, pixv, sv;

  logic signed [16:0] dx, dy;
  logic signed [33:0] dxx, dyy;
  logic [32:0]        sqx_r, sqx_nxt, sqy_r, sqy_nxt;
  logic [pcd_pkg::SQ_W-1:0] radv_r, radv_nxt;
  logic [17:0]        rrem_r, rrem_nxt;
  logic [16:0]        rres_r, rres_nxt, res_step;
  logic [19:0]        remsh, rtrial;
  logic               rge;
  logic [15:0]        radius_r, radius_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [2:0]         out_prim_r, out_prim_nxt;
  logic [pcd_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic               load_out;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_prim_r;
  assign out_tdata  = out_data_r;

  // Per-lane load values, reciprocal quotient and final scaling; even lanes are x.
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      absv[i]  = head.coord[i][15] ? (17'd0 - {1'b1, head.coord[i]})
                                   : {1'b0, head.coord[i]};
      prod[i]  = PW'(absv[i]) * (i[0] ? MUL_Y : MUL_X);
      qprod[i] = QW'(mag_r[i]) * QW'(i[0] ? RCP_Y : RCP_X);
      qv[i]    = PW'(qprod[i] >> (i[0] ? KY : KX));
      sv[i]    = neg_r[i] ? (16'd0 - quo_r[i][15:0]) : quo_r[i][15:0];
      pixv[i]  = i[0] ? (PY_TOP - sv[i]) : sv[i];
    end
  end

  assign dx  = $signed({pix_r[0][15], pix_r[0]}) - $signed({pix_r[2][15], pix_r[2]});
  assign dy  = $signed({pix_r[1][15], pix_r[1]}) - $signed({pix_r[3][15], pix_r[3]});
  assign dxx = dx * dx;
  assign dyy = dy * dy;

  assign remsh    = {rrem_r, radv_r[pcd_pkg::SQ_W-1 -: 2]};
  assign rtrial   = {1'b0, rres_r, 2'b01};
  assign rge      = remsh >= rtrial;
  assign res_step = {rres_r[15:0], rge};

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    prim_nxt     = prim_r;
    rop_nxt      = rop_r;
    colour_nxt   = colour_r;
    mag_nxt      = mag_r;
    quo_nxt      = quo_r;
    neg_nxt      = neg_r;
    pix_nxt      = pix_r;
    sqx_nxt      = sqx_r;
    sqy_nxt      = sqy_r;
    radv_nxt     = radv_r;
    rrem_nxt     = rrem_r;
    rres_nxt     = rres_r;
    radius_nxt   = radius_r;
    pop          = 1'b0;
    load_out     = 1'b0;
    case (state_r)
      pcd_pkg::BK_IDLE: begin
        if (!q_stat.empty) begin
          pop        = 1'b1;
          prim_nxt   = head.prim;
          rop_nxt    = head.rop;
          colour_nxt = head.colour;
          radius_nxt = 16'd0;
          if (head.prim == pcd_pkg::PRIM_NONE) begin
            pix_nxt   = '0;
            state_nxt = pcd_pkg::BK_DONE;
          end else begin
            for (int i = 0; i < 6; i++) begin
              mag_nxt[i] = prod[i];
              neg_nxt[i] = head.coord[i][15];
            end
            state_nxt = pcd_pkg::BK_DIV;
          end
        end
      end
      pcd_pkg::BK_DIV: begin
        quo_nxt   = qv;
        state_nxt = pcd_pkg::BK_SCALE;
      end
      pcd_pkg::BK_SCALE: begin
        pix_nxt = pixv;
        if (prim_r == pcd_pkg::PRIM_CIRCLE || prim_r == pcd_pkg::PRIM_DISC) begin
          state_nxt = pcd_pkg::BK_SQR;
        end else begin
          state_nxt = pcd_pkg::BK_DONE;
        end
      end
      pcd_pkg::BK_SQR: begin
        sqx_nxt   = dxx[32:0];
        sqy_nxt   = dyy[32:0];
        state_nxt = pcd_pkg::BK_SUM;
      end
      pcd_pkg::BK_SUM: begin
        radv_nxt  = pcd_pkg::SQ_W'(sqx_r) + pcd_pkg::SQ_W'(sqy_r);
        rrem_nxt  = '0;
        rres_nxt  = '0;
        cnt_nxt   = '0;
        state_nxt = pcd_pkg::BK_ROOT;
      end
      pcd_pkg::BK_ROOT: begin
        rrem_nxt = rge ? 18'(remsh - rtrial) : remsh[17:0];
        rres_nxt = res_step;
        radv_nxt = {radv_r[pcd_pkg::SQ_W-3:0], 2'b00};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(pcd_pkg::ROOT_STEPS - 1)) begin
          radius_nxt = res_step[16] ? 16'hFFFF : res_step[15:0];
          state_nxt  = pcd_pkg::BK_DONE;
        end
      end
      pcd_pkg::BK_DONE: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = pcd_pkg::BK_IDLE;
        end
      end
      default: state_nxt = pcd_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_prim_nxt  = out_prim_r;
    out_data_nxt  = out_data_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_prim_nxt  = prim_r;
      out_data_nxt  = {{PAD_W{1'b0}}, radius_r, pix_r[5], pix_r[4], pix_r[3],
                       pix_r[2], pix_r[1], pix_r[0], colour_r, rop_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pcd_pkg::BK_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prim_r     <= prim_nxt;
    rop_r      <= rop_nxt;
    colour_r   <= colour_nxt;
    mag_r      <= mag_nxt;
    quo_r      <= quo_nxt;
    neg_r      <= neg_nxt;
    pix_r      <= pix_nxt;
    sqx_r      <= sqx_nxt;
    sqy_r      <= sqy_nxt;
    radv_r     <= radv_nxt;
    rrem_r     <= rrem_nxt;
    rres_r     <= rres_nxt;
    radius_r   <= radius_nxt;
    out_prim_r <= out_prim_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ----- rtl/plot_command_decoder_top.sv -----
// Top level of the plot command decoder: register bank, front end, command
// queue and back end. Depends on pcd_pkg, pcd_regs, pcd_front, pcd_fifo, pcd_back.

// Each accepted item is one plot command and yields exactly one output item,
// in order. The front end updates the point history and queues the command in
// the cycle it is accepted; a two-entry queue lets it take further items while
// the back end works. The back end scales all three points at once, in
// registered steps: it multiplies each coordinate by the screen size, then by a
// rounded-up reciprocal of the logical size to get the truncated quotient, and
// last applies the sign and the vertical flip. A command that draws nothing
// skips the scaling; circles and discs add the squaring step, the sum and the
// 17-step square root loop. A result that is not taken holds the back end in its
// done state.
// Configuration must be written only while no item is in flight.
module plot_command_decoder_top #(
  parameter int SCREEN_WIDTH   = pcd_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT  = pcd_pkg::DEF_SCREEN_HEIGHT,
  parameter int LOGICAL_WIDTH  = pcd_pkg::DEF_LOGICAL_WIDTH,
  parameter int LOGICAL_HEIGHT = pcd_pkg::DEF_LOGICAL_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [pcd_pkg::CFG_AW-1:0]      cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tuser,  // plot_code[7:0]
  input  logic [pcd_pkg::IN_TDATA_W-1:0]  in_tdata,  // coord_x[15:0], coord_y[31:16]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [2:0]                      out_tuser, // primitive_res[2:0]
  // raster_op[2:0], colour_word[34:3], newest_px[50:35], newest_py[66:51],
  // previous_px[82:67], previous_py[98:83], oldest_px[114:99],
  // oldest_py[130:115], circle_radius[146:131], zero fill above
  output logic [pcd_pkg::OUT_TDATA_W-1:0] out_tdata
);

  pcd_pkg::cfg_t    cfg;
  pcd_pkg::q_push_t q_push;
  pcd_pkg::q_stat_t q_stat;
  pcd_pkg::cmd_t    head;
  logic             pop;

  pcd_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  pcd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .q_push    (q_push)
  );

  pcd_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .pop    (pop),
    .head   (head),
    .q_stat (q_stat)
  );

  pcd_back #(
    .SCREEN_WIDTH   (SCREEN_WIDTH),
    .SCREEN_HEIGHT  (SCREEN_HEIGHT),
    .LOGICAL_WIDTH  (LOGICAL_WIDTH),
    .LOGICAL_HEIGHT (LOGICAL_HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

`ifndef SYNTH
  a_none_is_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == pcd_pkg::PRIM_NONE) |-> (out_tdata == '0))
    else $error("empty command carries a nonzero payload");

  a_radius_circle_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != pcd_pkg::PRIM_CIRCLE && out_tuser != pcd_pkg::PRIM_DISC)
    |-> (out_tdata[146:131] == 16'd0))
    else $error("radius set on a primitive that is not a circle");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");
`endif

endmodule

// ----- tb/plot_command_checker.sv -----
// Checker for the plot command decoder: it watches the register, command and drawing ports,
// predicts each drawing command from its own history and register copy, and compares.
// Depends on pcd_pkg for the primitive, group, mode and register codes.
module plot_command_checker #(
  parameter int SCREEN_WIDTH   = pcd_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT  = pcd_pkg::DEF_SCREEN_HEIGHT,
  parameter int LOGICAL_WIDTH  = pcd_pkg::DEF_LOGICAL_WIDTH,
  parameter int LOGICAL_HEIGHT = pcd_pkg::DEF_LOGICAL_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic                            cfg_pready,
  input  logic [pcd_pkg::CFG_AW-1:0]      cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [7:0]                      in_tuser,  // plot_code[7:0]
  input  logic [pcd_pkg::IN_TDATA_W-1:0]  in_tdata,  // coord_x[15:0], coord_y[31:16]
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [2:0]                      out_tuser, // primitive_res[2:0]
  // raster_op[2:0], colour_word[34:3], newest_px[50:35], newest_py[66:51],
  // previous_px[82:67], previous_py[98:83], oldest_px[114:99],
  // oldest_py[130:115], circle_radius[146:131], zero fill above
  input  logic [pcd_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int                              mismatch_cnt,
  output int                              pending_cnt,
  output int                              checked_cnt,
  output int                              round_cnt
);
  import pcd_pkg::*;

  localparam longint SCR_W = SCREEN_WIDTH;
  localparam longint SCR_H = SCREEN_HEIGHT;
  localparam longint LOG_W = LOGICAL_WIDTH;
  localparam longint LOG_H = LOGICAL_HEIGHT;

  typedef struct packed {
    prim_t       prim;
    logic [2:0]  rop;
    logic [31:0] colour;
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] ox;
    logic [15:0] oy;
    logic [15:0] radius;
  } draw_cmd_t;

  logic        enable_r;
  logic [2:0]  fg_r;
  logic [2:0]  bg_r;
  logic [2:0]  action_r;
  // Index 0 is the newest point, 2 the oldest.
  logic [15:0] pt_x [3];
  logic [15:0] pt_y [3];
  draw_cmd_t   expected_cmds [$];

  function automatic logic [31:0] palette_abgr(input logic [2:0] idx);
    case (idx)
      3'd0: return 32'hFF000000;
      3'd1: return 32'hFF0000FF;
      3'd2: return 32'hFF00FF00;
      3'd3: return 32'hFF00FFFF;
      3'd4: return 32'hFFFF0000;
      3'd5: return 32'hFFFF00FF;
      3'd6: return 32'hFFFFFF00;
      default: return 32'hFFFFFFFF;
    endcase
  endfunction

  function automatic logic [15:0] scale_x(input logic [15:0] lx);
    longint v;
    v = longint'($signed(lx)) * SCR_W / LOG_W;
    return v[15:0];
  endfunction

  function automatic logic [15:0] scale_y(input logic [15:0] ly);
    longint v;
    v = (SCR_H - 1) - longint'($signed(ly)) * SCR_H / LOG_H;
    return v[15:0];
  endfunction

  function automatic longint floor_root(input longint v);
    longint r;
    longint t;
    r = 0;
    for (int b = 20; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  task automatic predict_draw(input logic [7:0] code, input logic [15:0] cx,
                              input logic [15:0] cy, output draw_cmd_t cmd);
    logic [1:0]  mode;
    logic [7:0]  grp;
    logic [15:0] nx;
    logic [15:0] ny;
    longint      dx;
    longint      dy;
    longint      r;
    cmd = '0;
    if (!enable_r) return;
    mode = code[1:0];
    grp  = code & GRP_MASK;
    if (code[2]) begin
      nx = cx;
      ny = cy;
    end else begin
      nx = pt_x[0] + cx;
      ny = pt_y[0] + cy;
    end
    pt_x[2] = pt_x[1];
    pt_y[2] = pt_y[1];
    pt_x[1] = pt_x[0];
    pt_y[1] = pt_y[0];
    pt_x[0] = nx;
    pt_y[0] = ny;
    if (grp == GRP_MOVE && mode == CMODE_MOVE) return;
    case (grp)
      GRP_POINT:     cmd.prim = PRIM_POINT;
      GRP_TRIANGLE:  cmd.prim = PRIM_TRIANGLE;
      GRP_RECTANGLE: cmd.prim = PRIM_RECTANGLE;
      GRP_CIRCLE:    cmd.prim = PRIM_CIRCLE;
      GRP_DISC:      cmd.prim = PRIM_DISC;
      default:       cmd.prim = PRIM_LINE;
    endcase
    cmd.rop    = (mode == CMODE_INVERT) ? ROP_EOR : action_r;
    cmd.colour = palette_abgr((mode == CMODE_BG) ? bg_r : fg_r);
    cmd.nx = scale_x(pt_x[0]);
    cmd.ny = scale_y(pt_y[0]);
    cmd.px = scale_x(pt_x[1]);
    cmd.py = scale_y(pt_y[1]);
    cmd.ox = scale_x(pt_x[2]);
    cmd.oy = scale_y(pt_y[2]);
    if (cmd.prim == PRIM_CIRCLE || cmd.prim == PRIM_DISC) begin
      dx = longint'($signed(cmd.nx)) - longint'($signed(cmd.px));
      dy = longint'($signed(cmd.ny)) - longint'($signed(cmd.py));
      r  = floor_root(dx * dx + dy * dy);
      cmd.radius = (r > 65535) ? 16'hFFFF : r[15:0];
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk) begin : watch
    draw_cmd_t want;
    if (!rst_n) begin
      enable_r = RST_ENABLE;
      fg_r     = RST_FG;
      bg_r     = RST_BG;
      action_r = RST_ACTION;
      for (int i = 0; i < 3; i++) begin
        pt_x[i] = '0;
        pt_y[i] = '0;
      end
      expected_cmds.delete();
      mismatch_cnt = 0;
      checked_cnt  = 0;
      round_cnt    = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[3:2]))
          REG_ENABLE: enable_r = cfg_pwdata[0];
          REG_FG:     fg_r     = cfg_pwdata[2:0];
          REG_BG:     bg_r     = cfg_pwdata[2:0];
          REG_ACTION: action_r = cfg_pwdata[2:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (expected_cmds.size() == 0) begin
          $error("drawing command arrived with none expected");
          mismatch_cnt++;
        end else begin
          want = expected_cmds.pop_front();
          check_field("primitive_res", 32'(want.prim), 32'(out_tuser));
          check_field("raster_op", 32'(want.rop), 32'(out_tdata[2:0]));
          check_field("colour_word", want.colour, out_tdata[34:3]);
          check_field("newest_px", 32'(want.nx), 32'(out_tdata[50:35]));
          check_field("newest_py", 32'(want.ny), 32'(out_tdata[66:51]));
          check_field("previous_px", 32'(want.px), 32'(out_tdata[82:67]));
          check_field("previous_py", 32'(want.py), 32'(out_tdata[98:83]));
          check_field("oldest_px", 32'(want.ox), 32'(out_tdata[114:99]));
          check_field("oldest_py", 32'(want.oy), 32'(out_tdata[130:115]));
          check_field("circle_radius", 32'(want.radius), 32'(out_tdata[146:131]));
          check_field("tdata fill", 32'd0, 32'(out_tdata[151:147]));
          checked_cnt++;
          if (want.prim == PRIM_CIRCLE || want.prim == PRIM_DISC) round_cnt++;
        end
      end
      if (in_tvalid && in_tready) begin
        predict_draw(in_tuser, in_tdata[15:0], in_tdata[31:16], want);
        expected_cmds.push_back(want);
      end
    end
    pending_cnt <= expected_cmds.size();
  end

endmodule

// ----- tb/tb_plot_command_decoder_top.sv -----
// Testbench top for the plot command decoder: clock, reset, register writes, command stimulus
// with random flow control, and the verdict. Depends on pcd_pkg, plot_command_decoder_top
// and plot_command_checker.
module tb_plot_command_decoder_top;
  import pcd_pkg::*;

  localparam logic [7:0] ABS_BIT      = 8'h04;
  localparam logic [7:0] UNUSED_GRP_A = 8'h08;
  localparam logic [7:0] UNUSED_GRP_B = 8'hF8;

  logic                        clk         = 1'b0;
  logic                        rst_n       = 1'b0;
  logic                        cfg_psel    = 1'b0;
  logic                        cfg_penable = 1'b0;
  logic                        cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0]           cfg_paddr   = '0;
  logic [31:0]                 cfg_pwdata  = '0;
  logic [31:0]                 cfg_prdata;
  logic                        cfg_pready;
  logic                        in_tvalid   = 1'b0;
  logic                        in_tready;
  logic [7:0]                  in_tuser    = '0;  // plot_code[7:0]
  logic [IN_TDATA_W-1:0]       in_tdata    = '0;  // coord_x[15:0], coord_y[31:16]
  logic                        out_tvalid;
  logic                        out_tready  = 1'b0;
  logic [2:0]                  out_tuser;         // primitive_res[2:0]
  // raster_op[2:0], colour_word[34:3], newest_px[50:35], newest_py[66:51],
  // previous_px[82:67], previous_py[98:83], oldest_px[114:99],
  // oldest_py[130:115], circle_radius[146:131], zero fill above
  logic [OUT_TDATA_W-1:0]      out_tdata;

  int sender_idle   = 0;
  int receiver_idle = 0;
  int settings_cnt  = 0;
  int mismatch_cnt;
  int pending_cnt;
  int checked_cnt;
  int round_cnt;

  plot_command_decoder_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tuser   (out_tuser),
    .out_tdata   (out_tdata)
  );

  plot_command_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_pready   (cfg_pready),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tuser     (in_tuser),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tuser    (out_tuser),
    .out_tdata    (out_tdata),
    .mismatch_cnt (mismatch_cnt),
    .pending_cnt  (pending_cnt),
    .checked_cnt  (checked_cnt),
    .round_cnt    (round_cnt)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= receiver_idle);
  end

  initial begin
    #(12 * 800000);
    $display("end of test: mismatches");
    $finish;
  end

  function automatic logic [7:0] plot_code(input logic [7:0] grp, input bit absolute,
                                           input logic [1:0] mode);
    return grp | (absolute ? ABS_BIT : 8'h00) | {6'd0, mode};
  endfunction

  function automatic logic [7:0] pick_group();
    case ($urandom_range(5))
      0: return GRP_MOVE;
      1: return GRP_POINT;
      2: return GRP_TRIANGLE;
      3: return GRP_RECTANGLE;
      4: return GRP_CIRCLE;
      default: return GRP_DISC;
    endcase
  endfunction

  function automatic logic [15:0] rand_coord(input bit absolute, input int span);
    int k;
    k = $urandom_range(9);
    if (k < 6) begin
      if (absolute) return 16'($urandom_range(span - 1));
      return 16'(int'($urandom_range(255)) - 128);
    end
    if (k < 9) return 16'($urandom);
    case ($urandom_range(3))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      default: return 16'h0000;
    endcase
  endfunction

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_settings(input logic en, input logic [2:0] fg, input logic [2:0] bg,
                                input logic [2:0] act);
    drain_results();
    write_reg(REG_ENABLE, {31'd0, en});
    write_reg(REG_FG, {29'd0, fg});
    write_reg(REG_BG, {29'd0, bg});
    write_reg(REG_ACTION, {29'd0, act});
    settings_cnt++;
  endtask

  task automatic send_cmd(input logic [7:0] code, input logic [15:0] x, input logic [15:0] y);
    while ($urandom_range(99) < sender_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= code;
    in_tdata  <= {y, x};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_random(output int sent);
    int          r;
    logic [7:0]  code;
    r = $urandom_range(99);
    if (r < 20) begin
      // Two placed points and then a shape that uses them.
      send_cmd(plot_code(GRP_MOVE, 1'b1, CMODE_MOVE), 16'($urandom_range(1279)),
               16'($urandom_range(1023)));
      send_cmd(plot_code(GRP_MOVE, 1'b1, CMODE_MOVE), 16'($urandom_range(1279)),
               16'($urandom_range(1023)));
      send_cmd(plot_code(pick_group(), 1'b1, 2'($urandom_range(1, 3))),
               16'($urandom_range(1279)), 16'($urandom_range(1023)));
      sent = 3;
    end else begin
      if (r < 65) code = pick_group() | 8'($urandom_range(7));
      else code = 8'($urandom_range(255));
      send_cmd(code, rand_coord(code[2], 1280), rand_coord(code[2], 1024));
      sent = 1;
    end
  endtask

  initial begin : stimulus
    int n;
    int k;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    sender_idle   = 26;
    receiver_idle = 60;

    // The block comes out of reset disabled, so these leave the history alone.
    send_cmd(plot_code(GRP_CIRCLE, 1'b1, CMODE_FG), 16'd640, 16'd512);
    send_cmd(plot_code(GRP_MOVE, 1'b1, CMODE_MOVE), 16'h7FFF, 16'h8000);

    apply_settings(1'b1, 3'd2, 3'd5, 3'd1);
    send_cmd(plot_code(GRP_MOVE, 1'b1, CMODE_MOVE), 16'd0, 16'd0);
    send_cmd(plot_code(GRP_MOVE, 1'b1, CMODE_FG), 16'd1279, 16'd1023);
    send_cmd(plot_code(GRP_MOVE, 1'b1, CMODE_INVERT), 16'h7FFF, 16'h7FFF);
    send_cmd(plot_code(GRP_MOVE, 1'b1, CMODE_BG), 16'h8000, 16'h8000);
    send_cmd(plot_code(GRP_MOVE, 1'b0, CMODE_FG), 16'h0001, 16'hFFFF);
    send_cmd(plot_code(GRP_MOVE, 1'b0, CMODE_MOVE), 16'h7FFF, 16'h0001);
    send_cmd(plot_code(GRP_POINT, 1'b1, CMODE_FG), 16'd640, 16'd512);
    send_cmd(plot_code(GRP_TRIANGLE, 1'b1, CMODE_FG), 16'd100, 16'd900);
    send_cmd(plot_code(GRP_RECTANGLE, 1'b1, CMODE_BG), 16'd1200, 16'd50);
    send_cmd(plot_code(GRP_CIRCLE, 1'b1, CMODE_FG), 16'd0, 16'd0);
    send_cmd(plot_code(GRP_DISC, 1'b1, CMODE_INVERT), 16'd640, 16'd512);
    send_cmd(plot_code(GRP_DISC, 1'b1, CMODE_BG), 16'h8000, 16'h7FFF);
    send_cmd(plot_code(UNUSED_GRP_A, 1'b0, CMODE_MOVE), 16'd5, 16'd5);
    send_cmd(plot_code(UNUSED_GRP_B, 1'b0, CMODE_MOVE), 16'hFFFB, 16'hFFFB);
    send_cmd(plot_code(UNUSED_GRP_B, 1'b1, CMODE_BG), 16'h7FFF, 16'h8000);
    send_cmd(plot_code(GRP_CIRCLE, 1'b1, CMODE_MOVE), 16'd0, 16'd0);
    send_cmd(plot_code(GRP_CIRCLE, 1'b0, CMODE_BG), 16'd0, 16'd0);
    send_cmd(plot_code(GRP_POINT, 1'b0, CMODE_INVERT), 16'hFFFF, 16'h0001);
    send_cmd(plot_code(GRP_TRIANGLE, 1'b0, CMODE_MOVE), 16'h8000, 16'h8000);
    send_cmd(plot_code(GRP_RECTANGLE, 1'b0, CMODE_INVERT), 16'h7FFF, 16'h7FFF);

    for (int ph = 0; ph < 3; ph++) begin
      sender_idle   = (ph == 0) ? 26 : (ph == 1) ? 60 : 0;
      receiver_idle = (ph == 0) ? 60 : (ph == 1) ? 26 : 0;
      for (int sub = 0; sub < 3; sub++) begin
        if (sub == 0 && ph == 0) apply_settings(1'b1, 3'd0, 3'd7, 3'd7);
        else if (sub == 0 && ph == 1) apply_settings(1'b1, 3'd7, 3'd0, 3'd0);
        else apply_settings(1'b1, 3'($urandom), 3'($urandom), 3'($urandom));
        n = 0;
        while (n < 160) begin
          send_random(k);
          n += k;
        end
      end
      if (ph == 0) begin
        // Disabled stretch; the history must survive it.
        apply_settings(1'b0, 3'd3, 3'd4, 3'd5);
        repeat (8) send_random(k);
      end
    end

    drain_results();
    repeat (60) @(posedge clk);
    $display("Covered %0d drawing commands under %0d register settings, %0d circles or discs,",
             checked_cnt, settings_cnt, round_cnt);
    $display("with sender and receiver stalling in turn and then running freely.");
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
